// ===== rtl/tleg_pkg.sv =====
// Shared constants for the triangular lattice edge generator.
package tleg_pkg;

  localparam int NODE_WIDTH = 26;

  localparam logic [1:0] PHASE_INTERIOR = 2'd0;
  localparam logic [1:0] PHASE_BORDER   = 2'd1;
  localparam logic [1:0] PHASE_RIGHT    = 2'd2;
  localparam logic [1:0] PHASE_SPARE    = 2'd3;

  localparam logic [2:0] SLOT_INTERIOR_LAST = 3'd5;
  localparam logic [2:0] SLOT_BORDER_LAST   = 3'd4;

  localparam logic REG_ROWS    = 1'b0;
  localparam logic REG_COLUMNS = 1'b1;

  typedef logic [NODE_WIDTH-1:0] node_t;

endpackage

// ===== rtl/triangular_lattice_edge_generator_core.sv =====
// Top level of the triangular lattice edge generator: edge walk and output register.
//
// Each input transaction requests the next edge of the lattice (restart = 1
// begins again at the first edge and returns it). One edge is produced per
// cycle unless out_stall holds a waiting edge: the request is taken while the
// previous edge still waits in the output register, and the edge appears in
// the cycle after acceptance. The cycle time is set by one band-by-stride
// multiplier followed by a chain of up to five dependent adds that form the
// node indices from the band and column counters. There is no clearing pass
// after reset. Write lattice_rows and lattice_columns only while no edge is
// pending; a count of zero makes every request report exhausted.
module triangular_lattice_edge_generator_core #(
  parameter int DIM_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tleg_pkg::node_t        source_node,
  output tleg_pkg::node_t        target_node,
  output logic                   last_edge,
  output logic                   exhausted,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [DIM_WIDTH-1:0]   cfg_data
);
  import tleg_pkg::*;

  localparam int D  = DIM_WIDTH;
  localparam int BW = D + 1;
  localparam int PW = 2 * D + 3;
  localparam int NW = NODE_WIDTH;

  logic [D-1:0]  lattice_rows;
  logic [D-1:0]  lattice_columns;
  logic [1:0]    phase;
  logic [BW-1:0] band_index;
  logic [D-1:0]  column_index;
  logic [2:0]    edge_slot;
  logic          done_flag;

  logic [1:0]    phase_next;
  logic [BW-1:0] band_index_next;
  logic [D-1:0]  column_index_next;
  logic [2:0]    edge_slot_next;
  logic          done_flag_next;

  logic          accept;
  logic [1:0]    cur_phase;
  logic [BW-1:0] cur_band;
  logic [D-1:0]  cur_col;
  logic [2:0]    cur_slot;
  logic          cur_done;
  logic          empty;

  logic [BW-1:0] stride;
  logic [BW-1:0] bands;
  logic [BW:0]   band_inc;
  logic [D:0]    col_inc;
  logic [BW:0]   factor;
  logic [PW-1:0] full_prod;
  node_t         prod;
  node_t         gw;
  node_t         mw;
  node_t         colw;
  node_t         c_node;
  node_t         u_node;
  node_t         r_node;
  node_t         src;
  node_t         dst;
  logic          last;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (restart) begin
      cur_phase = PHASE_INTERIOR;
      cur_band  = '0;
      cur_col   = '0;
      cur_slot  = '0;
      cur_done  = 1'b0;
    end else begin
      cur_phase = phase;
      cur_band  = band_index;
      cur_col   = column_index;
      cur_slot  = edge_slot;
      cur_done  = done_flag;
    end
  end

  assign empty = (lattice_rows == '0) || (lattice_columns == '0) || cur_done ||
                 (cur_phase == PHASE_SPARE);

  assign stride   = {lattice_columns, 1'b1};
  assign bands    = {lattice_rows, 1'b0} - BW'(1);
  assign band_inc = (BW+1)'(cur_band) + (BW+1)'(1);
  assign col_inc  = (D+1)'(cur_col) + (D+1)'(1);

  always_comb begin
    case (cur_phase)
      PHASE_INTERIOR: factor = band_inc;
      PHASE_BORDER:   factor = (BW+1)'({lattice_rows, 1'b0});
      default:        factor = (BW+1)'(cur_band);
    endcase
  end

  assign full_prod = PW'(factor) * PW'(stride);
  assign prod      = NW'(full_prod);
  assign gw        = NW'(stride);
  assign mw        = NW'(lattice_columns);
  assign colw      = NW'(cur_col);
  assign c_node    = prod + colw;
  assign u_node    = prod - gw + mw + colw;
  assign r_node    = prod + (mw << 1);

  always_comb begin
    src               = '0;
    dst               = '0;
    last              = 1'b0;
    phase_next        = cur_phase;
    band_index_next   = cur_band;
    column_index_next = cur_col;
    edge_slot_next    = cur_slot;
    done_flag_next    = cur_done;
    if (!empty) begin
      case (cur_phase)
        PHASE_INTERIOR: begin
          case (cur_slot)
            3'd0:    begin src = c_node; dst = c_node - gw;         end
            3'd1:    begin src = c_node; dst = u_node;              end
            3'd2:    begin src = c_node; dst = u_node + NW'(1);     end
            3'd3:    begin src = c_node; dst = u_node + gw;         end
            3'd4:    begin src = c_node; dst = u_node + gw + NW'(1); end
            default: begin src = u_node; dst = u_node + gw;         end
          endcase
          if (cur_slot >= SLOT_INTERIOR_LAST) begin
            edge_slot_next = '0;
            if (col_inc >= (D+1)'(lattice_columns)) begin
              column_index_next = '0;
              if (band_inc >= (BW+1)'(bands)) begin
                band_index_next = '0;
                phase_next      = PHASE_BORDER;
              end else begin
                band_index_next = band_inc[BW-1:0];
              end
            end else begin
              column_index_next = col_inc[D-1:0];
            end
          end else begin
            edge_slot_next = cur_slot + 3'd1;
          end
        end
        PHASE_BORDER: begin
          case (cur_slot)
            3'd0:    begin src = colw;   dst = mw + colw;          end
            3'd1:    begin src = colw;   dst = mw + colw + NW'(1); end
            3'd2:    begin src = c_node; dst = c_node - gw;        end
            3'd3:    begin src = c_node; dst = u_node;             end
            default: begin src = c_node; dst = u_node + NW'(1);    end
          endcase
          if (cur_slot >= SLOT_BORDER_LAST) begin
            edge_slot_next = '0;
            if (col_inc >= (D+1)'(lattice_columns)) begin
              column_index_next = '0;
              band_index_next   = '0;
              phase_next        = PHASE_RIGHT;
            end else begin
              column_index_next = col_inc[D-1:0];
            end
          end else begin
            edge_slot_next = cur_slot + 3'd1;
          end
        end
        default: begin
          src            = r_node;
          dst            = r_node + gw;
          edge_slot_next = '0;
          if (band_inc >= (BW+1)'(bands)) begin
            last            = 1'b1;
            done_flag_next  = 1'b1;
            band_index_next = '0;
          end else begin
            band_index_next = band_inc[BW-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_rows    <= D'(1);
      lattice_columns <= D'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROWS:    lattice_rows    <= cfg_data;
        REG_COLUMNS: lattice_columns <= cfg_data;
        default:     lattice_rows    <= lattice_rows;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_INTERIOR;
      band_index   <= '0;
      column_index <= '0;
      edge_slot    <= '0;
      done_flag    <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      band_index   <= band_index_next;
      column_index <= column_index_next;
      edge_slot    <= edge_slot_next;
      done_flag    <= done_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      source_node <= src;
      target_node <= dst;
      last_edge   <= last;
      exhausted   <= empty;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |-> source_node == '0 && target_node == '0 && !last_edge)
    else $error("exhausted transaction carries edge data");

  assert property (@(posedge clk) disable iff (rst)
    $rose(done_flag) |-> out_valid && last_edge && !exhausted)
    else $error("walk ended without marking the final edge");

  assert property (@(posedge clk) disable iff (rst)
    accept && !restart && done_flag |=> out_valid && exhausted)
    else $error("request after the end did not report exhausted");

  assert property (@(posedge clk) disable iff (rst)
    phase != PHASE_INTERIOR |-> edge_slot <= SLOT_BORDER_LAST)
    else $error("edge slot out of range outside the interior phase");

endmodule
